[rtl/brf_pkg.sv]
// shared constants and types for the byte ring fifo with statistics
// no dependencies; imported by brf_ctrl and the top level
`default_nettype none

package brf_pkg;

	// built depth default and fixed field widths
	localparam int DEPTH_DEF = 256;
	localparam int DATA_W    = 8;
	localparam int OCC_W     = 9;
	localparam int OVF_W     = 16;
	localparam int CAP_W     = 9;

	localparam logic [OVF_W-1:0] OVF_MAX = {OVF_W{1'b1}};

	// operation codes carried in func
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	// per-beat status handed from the control unit to the result register
	typedef struct packed {
		logic             ok;
		logic             pull;
		logic [OCC_W-1:0] occ;
		logic [OVF_W-1:0] ovf;
		logic [OCC_W-1:0] peak;
	} brf_stat_t;

endpackage

`default_nettype wire

[rtl/brf_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module brf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/brf_ctrl.sv]
// fifo bookkeeping: indices, fill level, overflow counter, watermark, capacity
// depends on brf_pkg
`default_nettype none

module brf_ctrl #(
	parameter int DEPTH = brf_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [brf_pkg::CAP_W-1:0] cfg_wdata,
	input  wire logic                      take,
	input  wire logic                      func,
	output logic                           mem_we,
	output logic                           mem_re,
	output logic      [AW-1:0]             wr_addr,
	output logic      [AW-1:0]             rd_addr,
	output brf_pkg::brf_stat_t             stat
);

	import brf_pkg::*;

	// index arithmetic width: room for index + 1 and for the capacity
	localparam int IW = (AW + 1 > CAP_W + 1) ? AW + 1 : CAP_W + 1;
	localparam logic [CAP_W-1:0] CAP_RST = CAP_W'((DEPTH < 256) ? DEPTH : 256);

	logic [AW-1:0]    wr_q, rd_q;
	logic [OCC_W-1:0] fill_q, peak_q;
	logic [OVF_W-1:0] ovf_q;
	logic [CAP_W-1:0] cap_q;

	logic             is_push, full, empty, do_push, do_pull, do_ovf;
	logic [OCC_W-1:0] fill_nxt, peak_nxt;
	logic [OVF_W-1:0] ovf_nxt;
	logic [IW-1:0]    wr_inc, rd_inc;
	logic [AW-1:0]    wr_nxt, rd_nxt;
	logic [CAP_W-1:0] cap_clamp;

	// decode the beat against the current fill level
	assign is_push = (func == FUNC_PUSH);
	assign full    = (fill_q >= OCC_W'(cap_q));
	assign empty   = (fill_q == '0);
	assign do_push = take & is_push & ~full;
	assign do_pull = take & ~is_push & ~empty;
	assign do_ovf  = take & is_push & full & (ovf_q != OVF_MAX);

	// index advance with wrap at the capacity in use
	assign wr_inc = IW'(wr_q) + IW'(1);
	assign rd_inc = IW'(rd_q) + IW'(1);
	assign wr_nxt = (wr_inc < IW'(cap_q)) ? wr_inc[AW-1:0] : '0;
	assign rd_nxt = (rd_inc < IW'(cap_q)) ? rd_inc[AW-1:0] : '0;

	// next statistics
	always_comb begin
		fill_nxt = fill_q;
		if (do_push) begin
			fill_nxt = fill_q + OCC_W'(1);
		end else if (do_pull) begin
			fill_nxt = fill_q - OCC_W'(1);
		end
	end

	assign peak_nxt = (fill_nxt > peak_q) ? fill_nxt : peak_q;
	assign ovf_nxt  = do_ovf ? ovf_q + OVF_W'(1) : ovf_q;

	// capacity clamp into 1 .. DEPTH
	always_comb begin
		cap_clamp = cfg_wdata;
		if (cfg_wdata == '0) begin
			cap_clamp = CAP_W'(1);
		end else if (32'(cfg_wdata) > 32'(DEPTH)) begin
			cap_clamp = CAP_W'(DEPTH);
		end
	end

	// state registers; a capacity write restarts the fifo
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			peak_q <= '0;
			ovf_q  <= '0;
			cap_q  <= CAP_RST;
		end else if (cfg_wen) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			peak_q <= '0;
			ovf_q  <= '0;
			cap_q  <= cap_clamp;
		end else begin
			if (do_push) begin
				wr_q <= wr_nxt;
			end
			if (do_pull) begin
				rd_q <= rd_nxt;
			end
			fill_q <= fill_nxt;
			peak_q <= peak_nxt;
			ovf_q  <= ovf_nxt;
		end
	end

	// memory commands and beat status
	assign mem_we  = do_push;
	assign mem_re  = do_pull;
	assign wr_addr = wr_q;
	assign rd_addr = rd_q;

	assign stat.ok   = do_push | do_pull;
	assign stat.pull = ~is_push;
	assign stat.occ  = fill_nxt;
	assign stat.ovf  = ovf_nxt;
	assign stat.peak = peak_nxt;

	// bookkeeping checks
	a_fill_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= OCC_W'(cap_q))
		else $error("fill level above capacity");

	a_peak_ge_fill: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= fill_q)
		else $error("watermark below fill level");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> wr_q == rd_q)
		else $error("indices differ on empty fifo");

	a_ovf_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wen |=> ovf_q >= $past(ovf_q))
		else $error("overflow counter went down");

endmodule

`default_nettype wire

[rtl/byte_ring_fifo_with_stats_unit.sv]
// byte ring fifo with statistics, top level: handshake, result register, byte store
// a result beat is valid in the cycle after its input beat is accepted
// throughput: one push or pull per cycle; input stalls only while a result waits
// the byte store is read through its registered read port in the cycle the pull is accepted
// reset: asynchronous, clears indices, counters, watermark; capacity to min(256, DEPTH)
// depends on brf_pkg, brf_ctrl, brf_ram
`default_nettype none

module byte_ring_fifo_with_stats_unit #(
	parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wen,
	input  wire logic [brf_pkg::CAP_W-1:0]  cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       func,
	input  wire logic [brf_pkg::DATA_W-1:0] push_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [brf_pkg::DATA_W-1:0] pulled_byte,
	output logic                            accepted,
	output logic      [brf_pkg::OCC_W-1:0]  occupancy,
	output logic      [brf_pkg::OVF_W-1:0]  overflow_total,
	output logic      [brf_pkg::OCC_W-1:0]  peak_occupancy
);

	import brf_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic              take, mem_we, mem_re, out_valid_q;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [DATA_W-1:0] rdata;
	brf_stat_t         stat, stat_s1;

	// input beat taken whenever the result register is free or draining
	assign in_stall = out_valid_q & out_stall;
	assign take     = in_valid & ~in_stall;

	brf_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.take     (take),
		.func     (func),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.stat     (stat)
	);

	brf_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wr_addr),
		.wdata(push_byte),
		.re   (mem_re),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (take) begin
			stat_s1 <= stat;
		end
	end

	// result ports; read data only counts on a successful pull
	assign out_valid      = out_valid_q;
	assign pulled_byte    = (stat_s1.ok & stat_s1.pull) ? rdata : '0;
	assign accepted       = stat_s1.ok;
	assign occupancy      = stat_s1.occ;
	assign overflow_total = stat_s1.ovf;
	assign peak_occupancy = stat_s1.peak;

	// result register checks
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("accepted beat produced no result");

	a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !take)
		else $error("beat taken over a waiting result");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pulled_byte) && $stable(accepted)
			&& $stable(occupancy) && $stable(overflow_total) && $stable(peak_occupancy))
		else $error("waiting result changed");

endmodule

`default_nettype wire
